### hdl/kfl_pkg.sv
// ----------------------------------------------------------------------------
// kfl_pkg
// Shared constants and controller/datapath interface types for the keyframe
// nearest lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package kfl_pkg;

  localparam int IDX_W     = 8;
  localparam int TIME_W    = 32;
  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = 5;

  // 50000.0 in Q16.16
  localparam logic [TIME_W:0] DIFF_LIMIT = 33'd3276800000;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] FIND_NEAREST = 2'd0;
  localparam logic [1:0] FIND_BEHIND  = 2'd1;
  localparam logic [1:0] FIND_FRONT   = 2'd2;

  typedef struct packed {
    logic load;
    logic capture;
    logic empty_reply;
    logic div_init;
    logic div_step;
    logic wrap;
    logic scan_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic no_period;
    logic div_last;
    logic scan_end;
  } sts_t;

endpackage

`default_nettype wire

### hdl/kfl_ram.sv
// ----------------------------------------------------------------------------
// kfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/kfl_datapath.sv
// ----------------------------------------------------------------------------
// kfl_datapath
// Key time store, valid bits, bit-serial remainder unit, sequential scan
// comparator and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module kfl_datapath #(
  parameter int MAX_FRAMES = 256
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire kfl_pkg::cmd_t                     cmd_i,
  output kfl_pkg::sts_t                          sts_o,
  input  wire logic [kfl_pkg::IDX_W-1:0]         frame_index_i,
  input  wire logic signed [kfl_pkg::TIME_W-1:0] frame_time_i,
  input  wire logic [1:0]                        find_type_i,
  output logic                                   done_o,
  output logic [kfl_pkg::IDX_W-1:0]              frame_number_o,
  output logic                                   found_o
);

  localparam int IW = kfl_pkg::IDX_W;
  localparam int TW = kfl_pkg::TIME_W;
  localparam int AW = $clog2(MAX_FRAMES);
  localparam int VD = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
  localparam int VW = $clog2(VD);

  logic            any_loaded_q;
  logic [IW-1:0]   highest_q;
  logic [VD-1:0]   valid_q;
  logic            rd_vld_q;
  logic [TW-1:0]   rdata;
  logic [TW-1:0]   key_rd;

  logic            t_neg_q;
  logic [TW-1:0]   n_q;
  logic [TW-1:0]   d_q;
  logic [TW-1:0]   r_q;
  logic [kfl_pkg::CNT_W-1:0] cnt_q;
  logic [1:0]      kind_q;
  logic signed [TW:0] wrap_q;

  logic [IW-1:0]   scan_idx_q;
  logic            cmp_vld_q;
  logic [IW-1:0]   cmp_idx_q;
  logic [TW:0]     least_q;
  logic [IW-1:0]   best_q;
  logic            hit_q;

  logic            done_q;
  logic [IW-1:0]   frame_number_q;
  logic            found_q;

  logic            in_range;
  logic            wr_en;
  logic [IW-1:0]   rd_idx;
  logic [IW+AW-1:0] wr_ext;
  logic [IW+AW-1:0] rd_ext;
  logic [IW+VW-1:0] wv_ext;
  logic [IW+VW-1:0] rv_ext;
  logic [TW-1:0]   t_mag;
  logic [TW-1:0]   p_mag;
  logic [TW:0]     trial;
  logic [TW:0]     trial_sub;
  logic            trial_ge;
  logic signed [TW:0] diff;
  logic [TW:0]     abs_diff;
  logic [IW-1:0]   result;

  assign in_range = 32'(frame_index_i) < 32'(MAX_FRAMES);
  assign wr_en    = cmd_i.load && in_range;
  assign rd_idx   = cmd_i.scan_step ? scan_idx_q : highest_q;

  assign wr_ext = {{AW{1'b0}}, frame_index_i};
  assign rd_ext = {{AW{1'b0}}, rd_idx};
  assign wv_ext = {{VW{1'b0}}, frame_index_i};
  assign rv_ext = {{VW{1'b0}}, rd_idx};

  kfl_ram #(
    .WIDTH(TW),
    .DEPTH(MAX_FRAMES)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_ext[AW-1:0]),
    .wdata_i(frame_time_i),
    .raddr_i(rd_ext[AW-1:0]),
    .rdata_o(rdata)
  );

  // never-written entries read as time zero
  assign key_rd = rd_vld_q ? rdata : '0;

  assign t_mag = frame_time_i[TW-1] ? (~frame_time_i) + 32'd1 : frame_time_i;
  assign p_mag = key_rd[TW-1] ? (~key_rd) + 32'd1 : key_rd;

  assign trial     = {r_q, n_q[TW-1]};
  assign trial_sub = trial - {1'b0, d_q};
  assign trial_ge  = trial >= {1'b0, d_q};

  assign diff     = $signed({key_rd[TW-1], key_rd}) - wrap_q;
  assign abs_diff = diff[TW] ? (~diff) + 33'd1 : diff;

  always_comb begin
    case (kind_q)
      kfl_pkg::FIND_BEHIND: begin
        result = (best_q == '0) ? highest_q - 8'd1 : best_q - 8'd1;
      end
      kfl_pkg::FIND_FRONT: begin
        result = (best_q == highest_q - 8'd1) ? '0 : best_q + 8'd1;
      end
      default: begin
        result = best_q;
      end
    endcase
  end

  assign sts_o.no_period = !any_loaded_q || (key_rd == '0);
  assign sts_o.div_last  = cnt_q == kfl_pkg::CNT_W'(kfl_pkg::DIV_STEPS - 1);
  assign sts_o.scan_end  = scan_idx_q == highest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_loaded_q   <= 1'b0;
      highest_q      <= '0;
      valid_q        <= '0;
      rd_vld_q       <= 1'b0;
      cmp_vld_q      <= 1'b0;
      done_q         <= 1'b0;
      frame_number_q <= '0;
      found_q        <= 1'b0;
    end else begin
      rd_vld_q  <= valid_q[rv_ext[VW-1:0]];
      cmp_vld_q <= cmd_i.scan_step;
      done_q    <= cmd_i.load || cmd_i.empty_reply || cmd_i.finish;
      found_q   <= 1'b0;
      if (cmd_i.load) begin
        any_loaded_q   <= 1'b1;
        frame_number_q <= frame_index_i;
        if (in_range) begin
          valid_q[wv_ext[VW-1:0]] <= 1'b1;
          if (frame_index_i > highest_q) begin
            highest_q <= frame_index_i;
          end
        end
      end else if (cmd_i.empty_reply) begin
        frame_number_q <= '0;
      end else if (cmd_i.finish) begin
        frame_number_q <= hit_q ? result : '0;
        found_q        <= hit_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      t_neg_q <= frame_time_i[TW-1];
      n_q     <= t_mag;
      kind_q  <= find_type_i;
    end
    if (cmd_i.div_init) begin
      d_q   <= p_mag;
      r_q   <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      r_q   <= trial_ge ? trial_sub[TW-1:0] : trial[TW-1:0];
      n_q   <= {n_q[TW-2:0], 1'b0};
      cnt_q <= cnt_q + 5'd1;
    end
    if (cmd_i.wrap) begin
      wrap_q     <= t_neg_q ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
      scan_idx_q <= '0;
      least_q    <= kfl_pkg::DIFF_LIMIT;
      best_q     <= '0;
      hit_q      <= 1'b0;
    end else begin
      if (cmd_i.scan_step) begin
        scan_idx_q <= scan_idx_q + 8'd1;
      end
      if (cmp_vld_q && (abs_diff < least_q)) begin
        least_q <= abs_diff;
        best_q  <= cmp_idx_q;
        hit_q   <= 1'b1;
      end
    end
    cmp_idx_q <= scan_idx_q;
  end

  assign done_o         = done_q;
  assign frame_number_o = frame_number_q;
  assign found_o        = found_q;

endmodule

`default_nettype wire

### hdl/kfl_ctrl.sv
// ----------------------------------------------------------------------------
// kfl_ctrl
// Query sequencer: period fetch, remainder iterations, scan and reply.
// ----------------------------------------------------------------------------
`default_nettype none

module kfl_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          mode_i,
  input  wire kfl_pkg::sts_t sts_i,
  output kfl_pkg::cmd_t      cmd_o,
  output logic               busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PERIOD,
    ST_DIVIDE,
    ST_WRAP,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (mode_i == kfl_pkg::MODE_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = ST_PERIOD;
          end
        end
      end
      ST_PERIOD: begin
        if (sts_i.no_period) begin
          cmd_o.empty_reply = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_WRAP;
        end
      end
      ST_WRAP: begin
        cmd_o.wrap = 1'b1;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != ST_IDLE;

endmodule

`default_nettype wire

### hdl/keyframe_nearest_lookup.sv
// ----------------------------------------------------------------------------
// keyframe_nearest_lookup
// Keyframe time table with wrapped nearest/behind/in-front frame search.
// ----------------------------------------------------------------------------
// A beat is taken when start_i is high and busy_o is low. A load beat leaves
// busy_o low, and the echo appears on the next cycle with done_o. A query
// holds busy_o through one period read, 32 remainder iterations of the
// bit-serial divider, one scanned frame per cycle through the single read
// port of the key RAM, plus setup, or only through the period read when
// nothing is loaded or the period is zero; its result follows on the next
// cycle. done_o is a single-cycle strobe and the receiver cannot stall it.
// The time table needs no clearing pass: per-entry valid bits make
// unwritten frames read as zero right after reset.
`default_nettype none

module keyframe_nearest_lookup #(
  parameter int MAX_FRAMES = 256
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic                              mode_i,
  input  wire logic [kfl_pkg::IDX_W-1:0]         frame_index_i,
  input  wire logic signed [kfl_pkg::TIME_W-1:0] frame_time_i,
  input  wire logic [1:0]                        find_type_i,
  output logic                                   done_o,
  output logic [kfl_pkg::IDX_W-1:0]              frame_number_o,
  output logic                                   found_o
);

  kfl_pkg::cmd_t cmd;
  kfl_pkg::sts_t sts;

  kfl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .mode_i (mode_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  kfl_datapath #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .frame_index_i (frame_index_i),
    .frame_time_i  (frame_time_i),
    .find_type_i   (find_type_i),
    .done_o        (done_o),
    .frame_number_o(frame_number_o),
    .found_o       (found_o)
  );

`ifndef SYNTHESIS
  a_found_only_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_o |-> done_o)
    else $error("found_o without done_o");

  a_query_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i == kfl_pkg::MODE_QUERY) |=> busy_o)
    else $error("query beat did not raise busy_o");

  a_load_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i == kfl_pkg::MODE_LOAD) |=>
      (done_o && !found_o && frame_number_o == $past(frame_index_i)))
    else $error("load beat echo mismatch");

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("done_o while busy_o");
`endif

endmodule

`default_nettype wire
